// ===== src/pcrc_pkg.sv =====
// Package for the packet CRC-32 checker: item types, CRC constants and
// the byte-wise CRC functions (runtime byte update and elaboration-time header matrix).
package pcrc_pkg;

  localparam int unsigned PAYLOAD_MAX_DEF = 1012;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam int unsigned SEQ_W  = 32;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned CRC_W  = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned HDR_MSG_W = 64;

  localparam int unsigned IN_TDATA_W  = SEQ_W + LEN_W + CRC_W + BYTE_W;
  localparam int unsigned OUT_TDATA_W = ((CRC_W + 2 + 7) / 8) * 8;

  typedef enum logic {
    MODE_HEADER  = 1'b0,
    MODE_PAYLOAD = 1'b1
  } pcrc_mode_t;

  typedef struct packed {
    pcrc_mode_t         mode;
    logic [SEQ_W-1:0]   sequence_number;
    logic [LEN_W-1:0]   data_length;
    logic [CRC_W-1:0]   received_crc;
    logic [BYTE_W-1:0]  data_byte;
  } pcrc_item_t;

  typedef logic [HDR_MSG_W-1:0][CRC_W-1:0] pcrc_cols_t;

  // One reflected CRC byte update, eight shift steps.
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Eight bytes, byte 0 in the low bits. Elaboration-time use only.
  function automatic logic [CRC_W-1:0] crc_msg(input logic [CRC_W-1:0] crc,
                                               input logic [HDR_MSG_W-1:0] msg);
    logic [CRC_W-1:0] c;
    c = crc;
    for (int k = 0; k < HDR_MSG_W / BYTE_W; k++) begin
      c = crc_byte(c, msg[k*BYTE_W +: BYTE_W]);
    end
    return c;
  endfunction

  // Contribution of each message bit to the header CRC (CRC is linear in the data).
  function automatic pcrc_cols_t hdr_cols();
    pcrc_cols_t cols;
    for (int i = 0; i < HDR_MSG_W; i++) begin
      cols[i] = crc_msg('0, HDR_MSG_W'(1) << i);
    end
    return cols;
  endfunction

  localparam logic [CRC_W-1:0] HDR_BASE = crc_msg(CRC_INIT, '0);
  localparam pcrc_cols_t       HDR_COLS = hdr_cols();

endpackage

// ===== src/pcrc_in_reg.sv =====
// Input register of the packet CRC-32 checker: holds one accepted item
// until the core takes it. Depends on pcrc_pkg.
module pcrc_in_reg
  import pcrc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  in_tuser,   // [0] mode
  input  logic [IN_TDATA_W-1:0] in_tdata,   // sequence_number, data_length, received_crc, data_byte
  output logic                  item_valid,
  output pcrc_item_t            item,
  input  logic                  item_take
);

  logic       valid_r;
  pcrc_item_t item_r;

  assign in_tready  = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.mode            <= pcrc_mode_t'(in_tuser);
      item_r.sequence_number <= in_tdata[SEQ_W-1:0];
      item_r.data_length     <= in_tdata[SEQ_W +: LEN_W];
      item_r.received_crc    <= in_tdata[SEQ_W+LEN_W +: CRC_W];
      item_r.data_byte       <= in_tdata[SEQ_W+LEN_W+CRC_W +: BYTE_W];
    end
  end

endmodule

// ===== src/pcrc_core.sv =====
// Packet state, CRC update and result register of the packet CRC-32 checker.
// Depends on pcrc_pkg.
module pcrc_core
  import pcrc_pkg::*;
#(
  parameter int unsigned PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   item_valid,
  input  pcrc_item_t             item,
  output logic                   item_take,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int unsigned CNT_W = $clog2(PAYLOAD_MAX + 1);

  logic [CRC_W-1:0]       running_crc_r, running_crc_nxt;
  logic [CNT_W-1:0]       bytes_left_r, bytes_left_nxt;
  logic [CRC_W-1:0]       expected_crc_r, expected_crc_nxt;
  logic                   in_packet_r, in_packet_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [HDR_MSG_W-1:0] hdr_msg;
  logic [CRC_W-1:0]     hdr_crc;
  logic [CRC_W-1:0]     pay_crc;
  logic [CNT_W-1:0]     bytes_dec;
  logic                 len_err;

  assign item_take  = item_valid && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // seq LSB first, two zero bytes, then length MSB first
  assign hdr_msg = {item.data_length[7:0], item.data_length[15:8], 16'h0000,
                    item.sequence_number};
  assign len_err = item.data_length > LEN_W'(PAYLOAD_MAX);

  always_comb begin
    hdr_crc = HDR_BASE;
    for (int i = 0; i < HDR_MSG_W; i++) begin
      hdr_crc = hdr_crc ^ (hdr_msg[i] ? HDR_COLS[i] : '0);
    end
  end

  assign pay_crc   = crc_byte(running_crc_r, item.data_byte);
  assign bytes_dec = bytes_left_r - CNT_W'(1);

  always_comb begin
    running_crc_nxt  = running_crc_r;
    bytes_left_nxt   = bytes_left_r;
    expected_crc_nxt = expected_crc_r;
    in_packet_nxt    = in_packet_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    out_data_nxt     = out_data_r;
    if (item_take) begin
      case (item.mode)
        MODE_HEADER: begin
          in_packet_nxt  = 1'b0;
          bytes_left_nxt = '0;
          if (len_err) begin
            running_crc_nxt = CRC_INIT;
            out_valid_nxt   = 1'b1;
            out_data_nxt    = OUT_TDATA_W'({1'b1, 1'b0, {CRC_W{1'b0}}});
          end else if (item.data_length == '0) begin
            running_crc_nxt = CRC_INIT;
            out_valid_nxt   = 1'b1;
            out_data_nxt    = OUT_TDATA_W'({1'b0, (~hdr_crc == item.received_crc),
                                            ~hdr_crc});
          end else begin
            running_crc_nxt  = hdr_crc;
            expected_crc_nxt = item.received_crc;
            bytes_left_nxt   = item.data_length[CNT_W-1:0];
            in_packet_nxt    = 1'b1;
          end
        end
        MODE_PAYLOAD: begin
          if (in_packet_r) begin
            bytes_left_nxt = bytes_dec;
            if (bytes_dec == '0) begin
              running_crc_nxt = CRC_INIT;
              in_packet_nxt   = 1'b0;
              out_valid_nxt   = 1'b1;
              out_data_nxt    = OUT_TDATA_W'({1'b0, (~pay_crc == expected_crc_r),
                                              ~pay_crc});
            end else begin
              running_crc_nxt = pay_crc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_crc_r  <= CRC_INIT;
      bytes_left_r   <= '0;
      expected_crc_r <= '0;
      in_packet_r    <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      running_crc_r  <= running_crc_nxt;
      bytes_left_r   <= bytes_left_nxt;
      expected_crc_r <= expected_crc_nxt;
      in_packet_r    <= in_packet_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== src/packet_crc32_checker.sv =====
// Top level of the packet CRC-32 checker: input register plus CRC core.
// Depends on pcrc_pkg, pcrc_in_reg and pcrc_core.
//
// Usage: the in_ stream carries header items (in_tuser = 0) with sequence
// number, payload length and received CRC, and payload bytes (in_tuser = 1).
// A header starts a packet and drops any open one. After the last payload
// byte, or with the header itself for length zero or an oversized length,
// one transfer on the out_ stream gives the reflected CRC-32 (over sequence
// number, length and payload), a match flag and a length error flag.
// Payload bytes outside a packet produce nothing.
// An input transfer is held in the input register and its result in the result register.
// Throughput: one item per cycle unless a pending result stalls; the header CRC is a
// constant XOR matrix and a payload byte is one unrolled eight-step CRC update, both
// between the input register and the result register.
// Reset: clears the packet state and both registers' valid flags.
// When out_tready is low with a result pending, the input register holds one
// item and in_tready drops until the result is taken.
module packet_crc32_checker
  import pcrc_pkg::*;
#(
  parameter int unsigned PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic                   in_tuser,   // [0] mode
  // [31:0] sequence_number, [47:32] data_length, [79:48] received_crc,
  // [87:80] data_byte
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [31:0] crc_value, [32] crc_match, [33] length_error, [39:34] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic       item_valid;
  logic       item_take;
  pcrc_item_t item;

  pcrc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  pcrc_core #(
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== src/pcrc_chk.sv =====
// Port-level checks for the packet CRC-32 checker, bound to its top level.
// Depends on pcrc_pkg.
module pcrc_chk
  import pcrc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_lerr_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[CRC_W+1] |-> out_tdata[CRC_W:0] == '0)
    else $error("length error result carries crc or match");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

endmodule

bind packet_crc32_checker pcrc_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== dv/packet_crc32_checker_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for packet_crc32_checker: random and directed packets with random
// stalls on both streams, results checked against an in-bench CRC-32 predictor.
// Depends on pcrc_pkg and the checker RTL only.
module packet_crc32_checker_test;
  import pcrc_pkg::*;

  typedef struct {
    logic [31:0] crc_value;
    logic        crc_match;
    logic        length_error;
  } crc_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic                   in_tuser = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  pcrc_item_t  packet_items[$];
  crc_result_t due_results[$];
  int          stimulus_count = 0;
  int          items_queued = 0;
  int          items_accepted = 0;
  int          results_seen = 0;
  int          mismatches = 0;

  // predictor state
  logic [31:0] run_crc = CRC_INIT;
  logic [9:0]  bytes_due = '0;
  logic [31:0] want_crc = '0;
  logic        pkt_open = 1'b0;

  packet_crc32_checker dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [31:0] crc_update(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
    end
    return r;
  endfunction

  // seq low byte first, then the length as a 32-bit word high byte first
  function automatic logic [31:0] header_crc(input logic [31:0] seq, input logic [15:0] len);
    logic [31:0] c;
    c = CRC_INIT;
    for (int k = 0; k < 4; k++) begin
      c = crc_update(c, seq[8*k +: 8]);
    end
    c = crc_update(c, 8'h00);
    c = crc_update(c, 8'h00);
    c = crc_update(c, len[15:8]);
    c = crc_update(c, len[7:0]);
    return c;
  endfunction

  function automatic void predict_checksum(input pcrc_item_t it);
    crc_result_t r;
    logic [31:0] c;
    if (it.mode == MODE_HEADER) begin
      pkt_open = 1'b0;
      bytes_due = '0;
      if (it.data_length > PAYLOAD_MAX_DEF) begin
        run_crc = CRC_INIT;
        r = '{32'h0, 1'b0, 1'b1};
        due_results.push_back(r);
      end else begin
        c = header_crc(it.sequence_number, it.data_length);
        if (it.data_length == 0) begin
          run_crc = CRC_INIT;
          r = '{~c, (~c == it.received_crc), 1'b0};
          due_results.push_back(r);
        end else begin
          run_crc = c;
          want_crc = it.received_crc;
          bytes_due = it.data_length[9:0];
          pkt_open = 1'b1;
        end
      end
    end else if (pkt_open) begin
      run_crc = crc_update(run_crc, it.data_byte);
      bytes_due = bytes_due - 10'd1;
      if (bytes_due == 0) begin
        r = '{~run_crc, (~run_crc == want_crc), 1'b0};
        due_results.push_back(r);
        pkt_open = 1'b0;
        run_crc = CRC_INIT;
      end
    end
  endfunction

  function automatic pcrc_item_t noise_item(input pcrc_mode_t m);
    pcrc_item_t it;
    it.mode = m;
    it.sequence_number = $urandom;
    it.data_length = 16'($urandom);
    it.received_crc = $urandom;
    it.data_byte = 8'($urandom);
    return it;
  endfunction

  // header with len, then the first 'sent' payload bytes; good selects a matching CRC
  task automatic add_packet(input int unsigned len, input int unsigned sent, input bit good,
                            input logic [31:0] seq);
    pcrc_item_t  h;
    pcrc_item_t  p;
    logic [31:0] c;
    logic [7:0]  bytes[$];
    h = noise_item(MODE_HEADER);
    h.sequence_number = seq;
    h.data_length = len[15:0];
    c = header_crc(seq, len[15:0]);
    if (len <= PAYLOAD_MAX_DEF) begin
      for (int i = 0; i < len; i++) begin
        bytes.push_back(8'($urandom));
        c = crc_update(c, bytes[i]);
      end
    end
    h.received_crc = good ? ~c : (~c ^ (32'h1 << $urandom_range(0, 31)));
    packet_items.push_back(h);
    for (int i = 0; i < sent; i++) begin
      p = noise_item(MODE_PAYLOAD);
      p.data_byte = bytes[i];
      packet_items.push_back(p);
    end
    stimulus_count += 1 + sent;
  endtask

  task automatic add_stray(input logic [7:0] b);
    pcrc_item_t p;
    p = noise_item(MODE_PAYLOAD);
    p.data_byte = b;
    packet_items.push_back(p);
    stimulus_count++;
  endtask

  function automatic int unsigned draw_wait(inout bit calm);
    if ($urandom_range(0, 63) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  // sender
  pcrc_item_t  tx_item;
  int unsigned tx_gap = 0;
  bit          tx_calm = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_checksum(tx_item);
        items_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (packet_items.size() > 0) begin
          tx_item = packet_items.pop_front();
          in_tuser <= tx_item.mode;
          in_tdata <= {tx_item.data_byte, tx_item.received_crc, tx_item.data_length,
                       tx_item.sequence_number};
          in_tvalid <= 1'b1;
          tx_gap = draw_wait(tx_calm);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  crc_result_t rx_want;
  int unsigned rx_stall = 0;
  bit          rx_calm = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (due_results.size() == 0) begin
          report_mismatch("unexpected result", out_tdata[31:0], 32'h0);
        end else begin
          rx_want = due_results.pop_front();
          if (out_tdata[31:0] !== rx_want.crc_value)
            report_mismatch("crc_value", out_tdata[31:0], rx_want.crc_value);
          if (out_tdata[32] !== rx_want.crc_match)
            report_mismatch("crc_match", 32'(out_tdata[32]), 32'(rx_want.crc_match));
          if (out_tdata[33] !== rx_want.length_error)
            report_mismatch("length_error", 32'(out_tdata[33]),
                            32'(rx_want.length_error));
          if (out_tdata[OUT_TDATA_W-1:34] !== '0)
            report_mismatch("pad bits", 32'(out_tdata[OUT_TDATA_W-1:34]), 32'h0);
        end
        rx_stall = draw_wait(rx_calm);
        // long hold-off so the input side backs up
        if (results_seen == 40) rx_stall = 400;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned k;
    int unsigned len;
    int unsigned sent;

    // directed
    add_packet(0, 0, 1'b1, 32'h0000_0000);
    add_packet(0, 0, 1'b0, 32'hFFFF_FFFF);
    add_packet(PAYLOAD_MAX_DEF + 1, 0, 1'b0, $urandom);
    add_packet(16'hFFFF, 0, 1'b0, $urandom);
    add_stray(8'h00);
    add_stray(8'hFF);
    add_packet(1, 1, 1'b1, 32'h8000_0001);
    add_packet(5, 2, 1'b1, $urandom);
    add_packet(2, 2, 1'b1, $urandom);
    add_packet(3, 3, 1'b0, $urandom);
    add_packet(4, 4, 1'b1, 32'hFFFF_FFFF);
    add_stray(8'($urandom));

    // random
    add_packet(PAYLOAD_MAX_DEF, PAYLOAD_MAX_DEF, 1'b1, $urandom);
    while (stimulus_count < 2000) begin
      k = $urandom_range(0, 99);
      if (k < 70) begin
        len = ($urandom_range(0, 49) == 0) ? $urandom_range(13, 300) : $urandom_range(0, 12);
        add_packet(len, len, ($urandom_range(0, 3) != 0), $urandom);
      end else if (k < 80) begin
        len = $urandom_range(2, 12);
        sent = $urandom_range(1, len - 1);
        add_packet(len, sent, 1'b1, $urandom);
      end else if (k < 90) begin
        add_packet($urandom_range(PAYLOAD_MAX_DEF + 1, 65535), 0, 1'b0, $urandom);
      end else begin
        repeat ($urandom_range(1, 3)) add_stray(8'($urandom));
      end
    end
    items_queued = packet_items.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    wait (items_accepted == items_queued);
    wait (due_results.size() == 0);
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
